FILE: rtl/mdsf_pkg.sv
package mdsf_pkg;

  // Build-time defaults
  localparam int MAX_SEEDS_DEF  = 1024;
  localparam int COORD_BITS_DEF = 12;

  // Field widths fixed by the register map and the stream format
  localparam int SIZE_W = 13;
  localparam int TGT_W  = 11;
  localparam int THR_W  = 26;
  localparam int CAND_W = 14;
  localparam int ID_W   = 11;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd4096;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd4096;
  localparam logic [TGT_W-1:0]  TARGET_RST = 11'd1024;
  localparam logic [THR_W-1:0]  THRESH_RST = 26'd0;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [TGT_W-1:0]  target;
    logic [THR_W-1:0]  thresh;
  } cfg_t;

endpackage

FILE: rtl/mdsf_core.sv
module mdsf_core #(
  parameter int MAX_SEEDS  = mdsf_pkg::MAX_SEEDS_DEF,
  parameter int COORD_BITS = mdsf_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mdsf_pkg::cfg_t                      cfg,
  // candidate side
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_new_set,
  input  logic signed [mdsf_pkg::CAND_W-1:0]  in_x,
  input  logic signed [mdsf_pkg::CAND_W-1:0]  in_y,
  // result side
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                res_accepted,
  output logic [COORD_BITS-1:0]               res_x,
  output logic [COORD_BITS-1:0]               res_y,
  output logic [mdsf_pkg::ID_W-1:0]           res_id,
  output logic                                res_full
);

  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int AW    = $clog2(MAX_SEEDS);
  localparam int LIM_W = (CNT_W > mdsf_pkg::TGT_W) ? CNT_W : mdsf_pkg::TGT_W;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SW    = (SQ_W + 1 > mdsf_pkg::THR_W) ? SQ_W + 1 : mdsf_pkg::THR_W;
  localparam int EXT_W = 17;
  localparam logic [EXT_W-1:0] SPAN     = EXT_W'(1 << COORD_BITS);
  localparam logic [LIM_W-1:0] MAX_LIM  = LIM_W'(MAX_SEEDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [mdsf_pkg::CAND_W-1:0] v,
    input logic [mdsf_pkg::SIZE_W-1:0]        size
  );
    logic [EXT_W-1:0] sz;
    logic [EXT_W-1:0] hi;
    logic [EXT_W-1:0] pos;
    logic [EXT_W-1:0] r;
    sz = EXT_W'(size);
    if (sz == '0) begin
      hi = '0;
    end else if (sz > SPAN) begin
      hi = SPAN - EXT_W'(1);
    end else begin
      hi = sz - EXT_W'(1);
    end
    pos = EXT_W'(v[mdsf_pkg::CAND_W-2:0]);
    if (v[mdsf_pkg::CAND_W-1]) begin
      r = '0;
    end else if (pos > hi) begin
      r = hi;
    end else begin
      r = pos;
    end
    return r[COORD_BITS-1:0];
  endfunction

  logic [1:0]            state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic [LIM_W-1:0]      lim;
  logic                  ok;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;

  // seed store: {y, x}
  logic [2*COORD_BITS-1:0] mem [MAX_SEEDS];
  logic [2*COORD_BITS-1:0] rd_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    we;
  logic [AW-1:0]           wr_addr;

  logic                  v1;
  logic                  v2;
  logic [SQ_W-1:0]       sqx;
  logic [SQ_W-1:0]       sqy;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic [COORD_BITS-1:0] sx;
  logic [COORD_BITS-1:0] sy;
  logic [SW-1:0]         d2;
  logic                  hit;

  logic                  in_fire;
  logic                  res_fire;
  logic [CNT_W-1:0]      count_start;
  logic [LIM_W-1:0]      lim_new;
  logic [CNT_W-1:0]      count_inc;
  logic [CNT_W-1:0]      count_after;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state == ST_DONE);
  assign res_fire  = res_valid && res_ready;

  assign count_start = in_new_set ? '0 : count;
  assign lim_new     = (LIM_W'(cfg.target) > MAX_LIM) ? MAX_LIM : LIM_W'(cfg.target);
  assign count_inc   = count + CNT_W'(1);
  assign count_after = ok ? count_inc : count;

  // scan issue: one seed read per cycle until a hit or the end of the store
  assign rd_en   = (state == ST_SCAN) && ok && (idx < count);
  assign rd_addr = idx[AW-1:0];
  assign we      = res_fire && ok;
  assign wr_addr = count[AW-1:0];

  assign sx = rd_data[COORD_BITS-1:0];
  assign sy = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign adx = (cx >= sx) ? cx - sx : sx - cx;
  assign ady = (cy >= sy) ? cy - sy : sy - cy;
  assign d2  = SW'(sqx) + SW'(sqy);
  assign hit = v2 && (d2 <= SW'(cfg.thresh));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {cy, cx};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      sqx <= adx * adx;
      sqy <= ady * ady;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      ok    <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            cx    <= clamp_coord(in_x, cfg.width);
            cy    <= clamp_coord(in_y, cfg.height);
            lim   <= lim_new;
            count <= count_start;
            ok    <= LIM_W'(count_start) < lim_new;
            idx   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            idx <= idx + CNT_W'(1);
          end
          if (hit) begin
            ok <= 1'b0;
          end
          // leave once nothing is issued and the compare pipe is empty
          if (!rd_en && !v1 && !v2) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_fire) begin
            count <= count_after;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res_accepted = ok;
  assign res_x        = cx;
  assign res_y        = cy;
  assign res_id       = ok ? mdsf_pkg::ID_W'(count_inc) : '0;
  assign res_full     = LIM_W'(count_after) >= lim;

  a_store_write: assert property (@(posedge clk) disable iff (rst)
    we |-> LIM_W'(count) < lim)
    else $error("seed written beyond limit");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    res_fire && ok |=> count == $past(count) + CNT_W'(1))
    else $error("seed count did not advance on accept");

  a_new_set: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_new_set |=> count == '0)
    else $error("new set did not clear the store");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    state != ST_SCAN |-> !v1 && !v2 && !rd_en)
    else $error("compare pipe active outside scan");

endmodule

FILE: rtl/min_distance_seed_filter.sv
// Channel   Dir  Signals                    Contents
// s_*       in   tvalid tready tdata tuser  candidate: tuser new_set, tdata cand_x, cand_y
// m_*       out  tvalid tready tdata tuser  result: tuser accepted, tdata seed_x .. set_full
// apb       in   psel penable pwrite paddr  registers: width, height, target, min_dist_sq
//
// Seed reads are issued at one per cycle during a scan (at most the seeds stored, at most
// MAX_SEEDS); the next input is taken only once the previous result has been committed.
// A seed that is too close ends the scan; up to two reads already in flight still drain.
// Reset (rst, synchronous) empties the store and loads register defaults.
// A result waiting on m_tready does not block the next candidate's scan; only the
// commit of that next result waits for the output register to drain.
module min_distance_seed_filter #(
  parameter int MAX_SEEDS  = mdsf_pkg::MAX_SEEDS_DEF,
  parameter int COORD_BITS = mdsf_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // candidate stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [13:0] cand_x, [27:14] cand_y
  input  logic        s_tuser,   // [0] new_set
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [((2*COORD_BITS+mdsf_pkg::ID_W+1+7)/8)*8-1:0] m_tdata,
                                 // seed_x, seed_y, seed_id, set_full
  output logic        m_tuser,   // [0] accepted
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OUT_DW = ((2*COORD_BITS + mdsf_pkg::ID_W + 1 + 7) / 8) * 8;

  mdsf_pkg::cfg_t cfg;
  logic [1:0]     reg_idx;
  logic           cfg_wr;

  logic                        res_valid;
  logic                        res_ready;
  logic                        res_accepted;
  logic [COORD_BITS-1:0]       res_x;
  logic [COORD_BITS-1:0]       res_y;
  logic [mdsf_pkg::ID_W-1:0]   res_id;
  logic                        res_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= mdsf_pkg::WIDTH_RST;
      cfg.height <= mdsf_pkg::HEIGHT_RST;
      cfg.target <= mdsf_pkg::TARGET_RST;
      cfg.thresh <= mdsf_pkg::THRESH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mdsf_pkg::REG_WIDTH:  cfg.width  <= pwdata[mdsf_pkg::SIZE_W-1:0];
        mdsf_pkg::REG_HEIGHT: cfg.height <= pwdata[mdsf_pkg::SIZE_W-1:0];
        mdsf_pkg::REG_TARGET: cfg.target <= pwdata[mdsf_pkg::TGT_W-1:0];
        mdsf_pkg::REG_THRESH: cfg.thresh <= pwdata[mdsf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mdsf_pkg::REG_WIDTH:  prdata = 32'(cfg.width);
      mdsf_pkg::REG_HEIGHT: prdata = 32'(cfg.height);
      mdsf_pkg::REG_TARGET: prdata = 32'(cfg.target);
      mdsf_pkg::REG_THRESH: prdata = 32'(cfg.thresh);
      default:              prdata = '0;
    endcase
  end

  mdsf_core #(
    .MAX_SEEDS  (MAX_SEEDS),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_new_set   (s_tuser),
    .in_x         (s_tdata[13:0]),
    .in_y         (s_tdata[27:14]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_accepted (res_accepted),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_id       (res_id),
    .res_full     (res_full)
  );

  // output register parts the scan from the downstream stall
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= OUT_DW'({res_full, res_id, res_y, res_x});
      m_tuser <= res_accepted;
    end
  end

endmodule
